### rtl/core/rfc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the record frame checker.
package rfc_pkg;

    // Header layout and payload bounds.
    localparam int unsigned HEADER_BYTES  = 20;
    localparam int unsigned OFFSET_W      = 17;
    localparam logic [OFFSET_W-1:0] PAYLOAD_LIMIT = 17'd65536;
    localparam logic [OFFSET_W-1:0] OFFSET_CAP    = 17'(HEADER_BYTES) + PAYLOAD_LIMIT;
    localparam logic [OFFSET_W-1:0] SHORT_POS     = 17'(HEADER_BYTES - 1);

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Register reset values.
    localparam logic [16:0] MAX_PAYLOAD_RESET = 17'd65536;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_MAX_LEN = 2'd2
    } reg_index_t;

    // Which part of the record a byte belongs to.
    typedef enum logic [2:0] {
        FLD_MAGIC    = 3'd0,
        FLD_VERSION  = 3'd1,
        FLD_RESERVED = 3'd2,
        FLD_LENGTH   = 3'd3,
        FLD_SEQUENCE = 3'd4,
        FLD_CHECKSUM = 3'd5,
        FLD_BODY     = 3'd6
    } field_t;

    // Outcome codes; among the error codes the lowest wins.
    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_MAGIC   = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_LENGTH  = 3'd4,
        ERR_TRUNC   = 3'd5,
        ERR_CRC     = 3'd6
    } err_t;

    // One classified byte, as the front hands it to the back.
    typedef struct packed {
        logic [7:0]          data_byte;
        logic                last_byte;
        field_t              field;
        logic [1:0]          lane;
        logic [OFFSET_W-1:0] payload_count;
        logic                short_rec;
    } item_t;

    // Configuration as seen by the back.
    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [16:0] max_payload_bytes;
    } cfg_t;

    // One result item, record_ok in the lowest bit.
    typedef struct packed {
        logic [16:0] payload_length;
        logic [31:0] record_sequence;
        logic [15:0] record_version;
        err_t        error_code;
        logic        record_ok;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // One byte through the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] r, input logic [7:0] b);
        logic [31:0] c;
        c = r ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/rfc_front.sv
// Front end: accepts bytes, counts the offset and classifies each byte.
module rfc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            q_full,
    output logic            in_ready,
    output logic            push,
    output rfc_pkg::item_t  item
);
    import rfc_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;

    // No item is taken while reset is held.
    assign in_ready = aresetn && !q_full;
    assign push     = in_valid && in_ready;

    // Saturating byte offset, cleared after the flagged byte.
    always_comb begin
        if (in_last) begin
            offset_next = '0;
        end else if (offset_reg == OFFSET_CAP) begin
            offset_next = OFFSET_CAP;
        end else begin
            offset_next = offset_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (push) begin
            offset_reg <= offset_next;
        end
    end

    // Map the offset onto a header field or the payload.
    always_comb begin
        item.data_byte     = in_byte;
        item.last_byte     = in_last;
        item.lane          = offset_reg[1:0];
        item.payload_count = offset_reg - SHORT_POS;
        item.short_rec     = offset_reg < SHORT_POS;
        priority if (offset_reg < 17'd4) begin
            item.field = FLD_MAGIC;
        end else if (offset_reg < 17'd6) begin
            item.field = FLD_VERSION;
        end else if (offset_reg < 17'd8) begin
            item.field = FLD_RESERVED;
        end else if (offset_reg < 17'd12) begin
            item.field = FLD_LENGTH;
        end else if (offset_reg < 17'd16) begin
            item.field = FLD_SEQUENCE;
        end else if (offset_reg < 17'(HEADER_BYTES)) begin
            item.field = FLD_CHECKSUM;
        end else begin
            item.field = FLD_BODY;
        end
    end

endmodule

### rtl/core/rfc_queue.sv
// Short queue of classified items between the front and the back.
module rfc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rfc_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output rfc_pkg::item_t  head
);
    import rfc_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/rfc_back.sv
// Back end: header capture, CRC over header and payload, final verdict and result register.
module rfc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  rfc_pkg::cfg_t    cfg,
    input  logic             q_not_empty,
    input  rfc_pkg::item_t   head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rfc_pkg::result_t out_data
);
    import rfc_pkg::*;

    logic [31:0] crc_reg,      crc_next;
    logic [31:0] magic_reg,    magic_next;
    logic [15:0] version_reg,  version_next;
    logic [31:0] length_reg,   length_next;
    logic [31:0] sequence_reg, sequence_next;
    logic [31:0] checksum_reg, checksum_next;
    logic        complete_reg, complete_next;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     result;
    logic        crc_feed;
    logic [7:0]  crc_byte_in;
    logic [16:0] limit;
    err_t        code;

    // A flagged item waits until the result register is free.
    assign pop       = q_not_empty && (!head.last_byte || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // State after this byte.
    always_comb begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        length_next   = length_reg;
        sequence_next = sequence_reg;
        checksum_next = checksum_reg;
        complete_next = complete_reg;
        crc_feed      = 1'b1;
        crc_byte_in   = head.data_byte;
        unique case (head.field)
            FLD_MAGIC:    magic_next[head.lane*8 +: 8]      = head.data_byte;
            FLD_VERSION:  version_next[head.lane[0]*8 +: 8] = head.data_byte;
            FLD_RESERVED: ;
            FLD_LENGTH:   length_next[head.lane*8 +: 8]     = head.data_byte;
            FLD_SEQUENCE: sequence_next[head.lane*8 +: 8]   = head.data_byte;
            FLD_CHECKSUM: begin
                checksum_next[head.lane*8 +: 8] = head.data_byte;
                crc_byte_in = 8'd0;
                // An empty payload is complete at the end of the header.
                if (head.lane == 2'd3 && length_reg == 32'd0) begin
                    complete_next = 1'b1;
                end
            end
            FLD_BODY: begin
                crc_feed = !complete_reg;
                if (!complete_reg && {15'd0, head.payload_count} == length_reg) begin
                    complete_next = 1'b1;
                end
            end
            default: ;
        endcase
        crc_next = crc_feed ? crc32_byte(crc_reg, crc_byte_in) : crc_reg;
    end

    // Verdict on the flagged byte, by priority.
    assign limit = (cfg.max_payload_bytes > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT
                                                           : cfg.max_payload_bytes;
    always_comb begin
        priority if (head.short_rec) begin
            code = ERR_SHORT;
        end else if (magic_next != cfg.magic_word) begin
            code = ERR_MAGIC;
        end else if (version_next != cfg.format_version) begin
            code = ERR_VERSION;
        end else if (length_next > {15'd0, limit}) begin
            code = ERR_LENGTH;
        end else if (!complete_next) begin
            code = ERR_TRUNC;
        end else if ((crc_next ^ CRC_ONES) != checksum_next) begin
            code = ERR_CRC;
        end else begin
            code = ERR_OK;
        end
        result.record_ok       = code == ERR_OK;
        result.error_code      = code;
        result.record_version  = (code == ERR_OK) ? version_next  : 16'd0;
        result.record_sequence = (code == ERR_OK) ? sequence_next : 32'd0;
        result.payload_length  = (code == ERR_OK) ? length_next[16:0] : 17'd0;
    end

    // Record state, cleared after each flagged byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= CRC_ONES;
            magic_reg    <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            sequence_reg <= '0;
            checksum_reg <= '0;
            complete_reg <= 1'b0;
        end else if (pop) begin
            if (head.last_byte) begin
                crc_reg      <= CRC_ONES;
                magic_reg    <= '0;
                version_reg  <= '0;
                length_reg   <= '0;
                sequence_reg <= '0;
                checksum_reg <= '0;
                complete_reg <= 1'b0;
            end else begin
                crc_reg      <= crc_next;
                magic_reg    <= magic_next;
                version_reg  <= version_next;
                length_reg   <= length_next;
                sequence_reg <= sequence_next;
                checksum_reg <= checksum_next;
                complete_reg <= complete_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop && head.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.last_byte) begin
            out_data_reg <= result;
        end
    end

    // The record state starts over after a flagged byte.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head.last_byte |=> crc_reg == CRC_ONES && !complete_reg && length_reg == 32'd0)
        else $error("record state not cleared after last item");

    // The ok flag agrees with the outcome code.
    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg.record_ok == (out_data_reg.error_code == ERR_OK))
        else $error("record_ok disagrees with error_code");

    // A failed record reports no header fields.
    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.record_ok |->
            out_data_reg.record_version == 16'd0 && out_data_reg.record_sequence == 32'd0
            && out_data_reg.payload_length == 17'd0)
        else $error("failed record carries header fields");

    // A pending result is never overwritten by the next flagged item.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |-> !(pop && head.last_byte))
        else $error("result overwritten while stalled");

endmodule

### rtl/core/record_frame_checker.sv
// Top level of the record frame checker: configuration registers and the front, queue and back.
//
// Bytes of a stored record enter on the s_ channel in address order, one item per byte,
// with s_tlast on the buffer's last byte. The first 20 bytes are the little-endian header
// (magic, version, reserved, length, sequence, checksum); a CRC-32 runs over the header with
// the checksum bytes as zeros and then over the payload. Bytes beyond the payload are ignored.
// Exactly one result item leaves on the m_ channel for each s_tlast item, none otherwise.
// Throughput is one byte per cycle while s_tready is high; it is set by the byte-wide CRC
// update in the back end. The last byte passes through the queue into the result register,
// which drives m_tvalid. The two-entry queue between front and back and the result register
// let the input keep flowing while a result waits; once a result stalls on m_tready, the
// input runs on until the next last byte waits at the head of the queue with one more item
// behind it, then s_tready drops.
// Configuration is written on the cfg_ channel (cfg_ready is high outside reset); the user
// must write it only while idle; the block does not enforce this. Index 0 is magic, 1 version,
// 2 the largest payload length; other indexes are ignored. Reset (aresetn low at a clock edge)
// empties the queue and result register, clears the byte offset and record state, and returns
// the registers to magic 0, version 0 and a payload limit of 65536. s_tready and cfg_ready stay
// low while aresetn is low. No clearing pass is needed after reset.
module record_frame_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input bytes.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // last_byte
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rfc_pkg::M_DATA_W-1:0] m_tdata,   // [0] record_ok, [3:1] error_code,
                                                    // [19:4] record_version,
                                                    // [51:20] record_sequence,
                                                    // [68:52] payload_length
    // Configuration writes.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);
    import rfc_pkg::*;

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   head;
    result_t result;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_not_empty;

    assign cfg_ready = aresetn;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word        <= '0;
            cfg_reg.format_version    <= '0;
            cfg_reg.max_payload_bytes <= MAX_PAYLOAD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAGIC:   cfg_reg.magic_word        <= cfg_data;
                REG_VERSION: cfg_reg.format_version    <= cfg_data[15:0];
                REG_MAX_LEN: cfg_reg.max_payload_bytes <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    rfc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_ready (s_tready),
        .push     (push),
        .item     (front_item)
    );

    rfc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    rfc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (result)
    );

    assign m_tdata = {{(M_DATA_W - RESULT_W){1'b0}}, result};

endmodule

### tb/record_frame_checker_tb.sv
// Self-checking testbench for record_frame_checker: directed and random records against a predictor.
`timescale 1ns / 100ps

module record_frame_checker_tb;
    import rfc_pkg::*;

    // Run control.
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned WHOLE_FRAME   = 32'hFFFF_FFFF;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    // Predicts one outcome per record and checks the result items against them in order.
    class record_outcome_board;
        logic [31:0] magic_cfg;
        logic [15:0] version_cfg;
        logic [16:0] max_len_cfg;

        int unsigned byte_pos;
        logic [31:0] crc_acc;
        logic [31:0] magic_got;
        logic [15:0] version_got;
        logic [31:0] length_got;
        logic [31:0] sequence_got;
        logic [31:0] checksum_got;
        bit          body_done;

        result_t     outcome_q[$];
        int unsigned fail_count;
        int unsigned result_count;
        int unsigned code_hits[7];

        // Reflected CRC-32, one data bit per shift.
        static function logic [31:0] crc_step(logic [31:0] acc_in, logic [7:0] b);
            logic [31:0] acc;
            acc = acc_in;
            for (int k = 0; k < 8; k++) begin
                acc = {1'b0, acc[31:1]} ^ ((acc[0] ^ b[k]) ? CRC_POLY : 32'd0);
            end
            return acc;
        endfunction

        function void clear_record();
            byte_pos     = 0;
            crc_acc      = CRC_ONES;
            magic_got    = '0;
            version_got  = '0;
            length_got   = '0;
            sequence_got = '0;
            checksum_got = '0;
            body_done    = 1'b0;
        endfunction

        function void reset_all();
            magic_cfg    = '0;
            version_cfg  = '0;
            max_len_cfg  = MAX_PAYLOAD_RESET;
            fail_count   = 0;
            result_count = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
            clear_record();
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction

        // Unknown indexes leave every register as it was.
        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MAGIC:   magic_cfg = val;
                REG_VERSION: version_cfg = val[15:0];
                REG_MAX_LEN: max_len_cfg = val[16:0];
                default: ;
            endcase
        endfunction

        // Consumes one accepted byte; a flagged byte closes the record with an outcome.
        function void take_byte(logic [7:0] b, logic last);
            int unsigned pos;
            int unsigned lane_sh;
            int unsigned limit;
            err_t        code;
            result_t     want;
            pos = byte_pos;
            if (pos < HEADER_BYTES) begin
                lane_sh = (pos % 4) * 8;
                if (pos < 4) begin
                    magic_got[lane_sh +: 8] = b;
                end else if (pos < 6) begin
                    version_got[lane_sh +: 8] = b;
                end else if (pos >= 8 && pos < 12) begin
                    length_got[lane_sh +: 8] = b;
                end else if (pos >= 12 && pos < 16) begin
                    sequence_got[lane_sh +: 8] = b;
                end else if (pos >= 16) begin
                    checksum_got[lane_sh +: 8] = b;
                end
                // The stored checksum enters the CRC as zeros.
                crc_acc = crc_step(crc_acc, (pos < 16) ? b : 8'd0);
                if (pos == HEADER_BYTES - 1 && length_got == 0) body_done = 1'b1;
            end else if (!body_done) begin
                crc_acc = crc_step(crc_acc, b);
                if (pos - HEADER_BYTES + 1 == length_got) body_done = 1'b1;
            end
            // The byte counter saturates; bytes past the payload only move it.
            byte_pos = (pos + 1 > OFFSET_CAP) ? OFFSET_CAP : pos + 1;
            if (!last) return;

            limit = (max_len_cfg > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_len_cfg;
            if (byte_pos < HEADER_BYTES) code = ERR_SHORT;
            else if (magic_got != magic_cfg) code = ERR_MAGIC;
            else if (version_got != version_cfg) code = ERR_VERSION;
            else if (length_got > limit) code = ERR_LENGTH;
            else if (!body_done) code = ERR_TRUNC;
            else if ((crc_acc ^ CRC_ONES) != checksum_got) code = ERR_CRC;
            else code = ERR_OK;

            want.record_ok       = (code == ERR_OK);
            want.error_code      = code;
            want.record_version  = (code == ERR_OK) ? version_got : 16'd0;
            want.record_sequence = (code == ERR_OK) ? sequence_got : 32'd0;
            want.payload_length  = (code == ERR_OK) ? length_got[16:0] : 17'd0;
            outcome_q.push_back(want);
            clear_record();
        endfunction

        function void report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        endfunction

        function void check_outcome(logic [M_DATA_W-1:0] bus);
            result_t got;
            result_t want;
            got = bus[RESULT_W-1:0];
            result_count++;
            if (outcome_q.size() == 0) begin
                fail_count++;
                $display("%0t: result item with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = outcome_q.pop_front();
            code_hits[want.error_code]++;
            if (got.record_ok !== want.record_ok)
                report_field("record_ok", want.record_ok, got.record_ok);
            if (got.error_code !== want.error_code)
                report_field("error_code", want.error_code, got.error_code);
            if (got.record_version !== want.record_version)
                report_field("record_version", want.record_version, got.record_version);
            if (got.record_sequence !== want.record_sequence)
                report_field("record_sequence", want.record_sequence, got.record_sequence);
            if (got.payload_length !== want.payload_length)
                report_field("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] data_byte
    logic                s_tlast;   // last_byte
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [0] record_ok, [3:1] error_code, [19:4] record_version,
                                    // [51:20] record_sequence, [68:52] payload_length
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;

    record_outcome_board outcomes;
    logic [7:0]          frame_q[$];
    int unsigned         core_len;
    int unsigned         core_bytes;
    int unsigned         cycle_count;
    bit                  tx_idle;
    bit                  rx_idle;
    bit                  hold_req;
    logic [31:0]         dir_magic;
    logic [15:0]         dir_version;

    record_frame_checker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Handshake monitors on all three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) outcomes.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) outcomes.check_outcome(m_tdata);
            if (cfg_valid && cfg_ready) outcomes.write_reg(cfg_index, cfg_data);
        end
    end

    // Result receiver: random stalls per item while rx_idle is set, plus one long hold-off on request.
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !hold_req);
        end
    end

    // Offers one byte, after a random gap while tx_idle is set, and returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends the first cut bytes of the built record, flagging the final one.
    task automatic send_frame(input int unsigned cut);
        int unsigned n;
        n = (frame_q.size() < cut) ? frame_q.size() : cut;
        core_bytes += (n < core_len) ? n : core_len;
        for (int unsigned k = 0; k < n; k++) send_byte(frame_q[k], k == n - 1);
    endtask

    // Stops offering bytes and waits until every outcome has arrived and the block settles.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcomes.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic cfg_rest();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [15:0] version,
                              input logic [31:0] max_len);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, version);
        write_reg(REG_MAX_LEN, max_len);
        cfg_rest();
    endtask

    // Builds a record with a checksum over the header and the covered payload; bad_sum flips one bit.
    function automatic void build_record(input logic [31:0] magic, input logic [15:0] version,
                                         input logic [31:0] length_field,
                                         input logic [31:0] seq, input int unsigned body_n,
                                         input int unsigned tail_n, input bit bad_sum);
        logic [31:0] check_val;
        int unsigned covered;
        frame_q.delete();
        for (int k = 0; k < 4; k++) frame_q.push_back(magic[8*k +: 8]);
        frame_q.push_back(version[7:0]);
        frame_q.push_back(version[15:8]);
        repeat (2) frame_q.push_back(8'($urandom));
        for (int k = 0; k < 4; k++) frame_q.push_back(length_field[8*k +: 8]);
        for (int k = 0; k < 4; k++) frame_q.push_back(seq[8*k +: 8]);
        repeat (4) frame_q.push_back(8'd0);
        repeat (body_n) frame_q.push_back(8'($urandom));
        covered = (length_field < body_n) ? length_field : body_n;
        check_val = CRC_ONES;
        for (int unsigned k = 0; k < HEADER_BYTES + covered; k++)
            check_val = record_outcome_board::crc_step(check_val, frame_q[k]);
        check_val ^= CRC_ONES;
        if (bad_sum) check_val ^= 32'h1 << $urandom_range(0, 31);
        for (int k = 0; k < 4; k++) frame_q[16 + k] = check_val[8*k +: 8];
        repeat (tail_n) frame_q.push_back(8'($urandom));
        core_len = HEADER_BYTES + covered;
    endfunction

    // One random record: mostly well formed, the rest broken in one way or pure noise.
    task automatic random_record();
        int unsigned pick;
        int unsigned limit;
        int unsigned body;
        int unsigned cut;
        logic [31:0] magic;
        logic [31:0] lenf;
        logic [15:0] version;
        bit          bad;
        limit   = (outcomes.max_len_cfg > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : outcomes.max_len_cfg;
        lenf    = $urandom_range(0, (limit < 24) ? limit : 24);
        body    = lenf;
        magic   = outcomes.magic_cfg;
        version = outcomes.version_cfg;
        cut     = WHOLE_FRAME;
        bad     = 1'b0;
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 99);
        if (pick >= 95) begin
            frame_q.delete();
            repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
            core_len = frame_q.size();
            send_frame(WHOLE_FRAME);
            return;
        end
        if (pick < 65) begin
        end else if (pick < 70) begin
            magic ^= 32'h1 << $urandom_range(0, 31);
        end else if (pick < 75) begin
            version ^= 16'h1 << $urandom_range(0, 15);
        end else if (pick < 80) begin
            lenf = ($urandom_range(0, 1) != 0) ? limit + 1 + $urandom_range(0, 300)
                                               : ($urandom | 32'h0002_0000);
            body = $urandom_range(0, 8);
        end else if (pick < 85 && limit > 0) begin
            if (lenf == 0) lenf = 1;
            body = $urandom_range(0, lenf - 1);
        end else if (pick < 90) begin
            bad = 1'b1;
        end else begin
            cut = $urandom_range(1, HEADER_BYTES - 1);
        end
        build_record(magic, version, lenf, $urandom, body,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, bad);
        send_frame(cut);
    endtask

    task automatic random_phase(input int unsigned goal);
        int unsigned start;
        start = core_bytes;
        while (core_bytes - start < goal) random_record();
    endtask

    initial begin
        outcomes = new;
        outcomes.reset_all();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        core_bytes = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        hold_req   = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at their reset values: empty payload, records cut off in the header, and a three-byte payload.
        build_record(32'd0, 16'd0, 32'd0, 32'd0, 0, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        send_frame(1);
        send_frame(HEADER_BYTES - 1);
        build_record(32'd0, 16'd0, 32'd3, 32'hFFFF_FFFF, 3, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        drain_results();

        // All-ones identity and a zero payload limit; a write to an unknown index is dropped.
        set_config(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        write_reg(REG_UNUSED, $urandom);
        cfg_rest();
        build_record(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 0, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(32'hFFFF_FFFF, 16'hFFFF, 32'd1, $urandom, 1, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(32'd0, 16'hFFFF, 32'd0, $urandom, 0, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(32'hFFFF_FFFF, 16'h7FFF, 32'd0, $urandom, 0, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(32'hFFFF_FFFF, 16'hFFFF, 32'd0, $urandom, 0, 0, 1'b1);
        send_frame(WHOLE_FRAME);
        // A short record wins over its bad magic.
        build_record(32'h1234_5678, 16'hFFFF, 32'd0, $urandom, 0, 0, 1'b0);
        send_frame(5);
        drain_results();

        // Limit register written with upper bits set; it is capped at the payload limit.
        dir_magic   = $urandom;
        dir_version = $urandom;
        set_config(dir_magic, dir_version, 32'hFFFF_FFFF);
        build_record(dir_magic, dir_version, 32'd5, $urandom, 2, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(dir_magic, dir_version, 32'd65537, $urandom, 4, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(dir_magic, dir_version, 32'hFFFF_FFFF, $urandom, 2, 0, 1'b0);
        send_frame(WHOLE_FRAME);
        // Bytes after the payload are ignored by the checksum.
        build_record(dir_magic, dir_version, 32'd3, $urandom, 3, 6, 1'b0);
        send_frame(WHOLE_FRAME);
        build_record(dir_magic, ~dir_version, 32'd8, $urandom, 8, 0, 1'b1);
        send_frame(WHOLE_FRAME);
        build_record(dir_magic, dir_version, 32'd9, $urandom, 4, 0, 1'b1);
        send_frame(WHOLE_FRAME);
        drain_results();

        // A longer payload with a tail, both sides running without gaps.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        build_record(dir_magic, dir_version, 32'd60, $urandom, 60, 40, 1'b0);
        send_frame(WHOLE_FRAME);
        drain_results();

        // Receiver holds off while one-byte records pile up and back-pressure the input.
        hold_req = 1'b1;
        repeat (16) begin
            build_record($urandom, $urandom, $urandom, $urandom, 0, 0, 1'b0);
            send_frame(1);
        end
        while (hold_req) @(negedge aclk);
        drain_results();

        // Random records under several register settings.
        set_config($urandom, $urandom, 32'd64);
        random_phase(350);
        drain_results();
        set_config(32'd0, 16'hFFFF, 32'd0);
        random_phase(250);
        drain_results();
        set_config(32'hFFFF_FFFF, 16'd0, 32'd65536);
        random_phase(400);
        drain_results();
        set_config($urandom, $urandom, 32'h0001_FFFF);
        random_phase(400);
        drain_results();

        $display("Checked %0d result items from %0d header and payload bytes, %0d passed.",
                 outcomes.result_count, core_bytes, outcomes.code_hits[ERR_OK]);
        $display("Failures: short %0d, magic %0d, version %0d, length %0d, trunc %0d, crc %0d.",
                 outcomes.code_hits[ERR_SHORT], outcomes.code_hits[ERR_MAGIC],
                 outcomes.code_hits[ERR_VERSION], outcomes.code_hits[ERR_LENGTH],
                 outcomes.code_hits[ERR_TRUNC], outcomes.code_hits[ERR_CRC]);
        if (outcomes.fail_count == 0 && outcomes.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rfc_pkg.sv
rtl/core/rfc_front.sv
rtl/core/rfc_queue.sv
rtl/core/rfc_back.sv
rtl/core/record_frame_checker.sv
tb/record_frame_checker_tb.sv
